// ===== sv/waypoint_sequencer_with_dwell_defines.svh =====
// assertion macros shared by the waypoint sequencer rtl
`ifndef WAYPOINT_SEQUENCER_WITH_DWELL_DEFINES_SVH
`define WAYPOINT_SEQUENCER_WITH_DWELL_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on i_clk, quiet during reset
`define WPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("waypoint sequencer check failed");

// next-cycle implication, sampled on i_clk, quiet during reset
`define WPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("waypoint sequencer check failed");

`else

`define WPS_ASSERT_IMP(label, ante, cons)
`define WPS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== sv/wps_pkg.sv =====
`default_nettype none

package wps_pkg;

    // table geometry and field widths
    localparam int MAX_WAYPOINTS = 256;
    localparam int COORD_BITS    = 24;
    localparam int HEAD_BITS     = 16;
    localparam int ENTRY_W       = 8;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 9;
    localparam int THR_W         = 50;
    localparam int TIDX_W        = 8;

    // index of a table entry, and a count that can hold the depth itself
    localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int STEP_W = $clog2(CNT_W);

    // difference, square and three-term sum
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ACC_W  = 2 * COORD_BITS + 2;
    localparam int CMP_W  = (ACC_W > THR_W) ? ACC_W : THR_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [COUNT_W-1:0] WP_COUNT_RST = COUNT_W'(1);
    localparam logic [THR_W-1:0]   THR_RST      = THR_W'(838861);
    localparam logic [TIME_W-1:0]  DWELL_RST    = TIME_W'(5000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WP_COUNT   = 2'd0,
        CFG_ARRIVE_THR = 2'd1,
        CFG_DWELL      = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic                         req_type;
        logic [ENTRY_W-1:0]           entry_index;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic signed [HEAD_BITS-1:0]  heading;
        logic [TIME_W-1:0]            now_ms;
    } t_req;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic signed [COORD_BITS-1:0] target_z;
        logic signed [HEAD_BITS-1:0]  target_heading;
        logic [TIDX_W-1:0]            target_index;
        logic                         arrived;
    } t_rsp;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic signed [HEAD_BITS-1:0]  heading;
    } t_wp_entry;

endpackage

`default_nettype wire

// ===== sv/wps_req_if.sv =====
`default_nettype none

interface wps_req_if
    import wps_pkg::*;
;
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/wps_rsp_if.sv =====
`default_nettype none

interface wps_rsp_if
    import wps_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/waypoint_sequencer_with_dwell.sv =====
`default_nettype none
`include "waypoint_sequencer_with_dwell_defines.svh"

// Waypoint sequencer with arrival dwell. Load beats (req_type 0) write one entry of a
// 256-entry waypoint table; sample beats (req_type 1) compare the vehicle position with
// the current target by squared distance, latch arrival when it drops below the
// threshold, and advance the index (wrapping at waypoint_count) once more than dwell_ms
// has passed since arrival. Every beat returns one result with the current target.
// One item is worked at a time and i_req.ready is high only between items. The three
// squares go one per cycle through a single 25x25 multiplier, and the wrap of the
// advanced index runs through a bit-serial remainder unit, one bit per cycle.
// A finished result waits in the output register without blocking the next accept.
// The table has no reset; reading an entry never loaded gives undefined target fields.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must do so
// only while the block idles, as the block itself does not enforce it.
module waypoint_sequencer_with_dwell
    import wps_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    wps_req_if.sink                    i_req,
    wps_rsp_if.source                  o_rsp
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MX    = 10'b00_0000_0010,
        S_MY    = 10'b00_0000_0100,
        S_MZ    = 10'b00_0000_1000,
        S_ACC   = 10'b00_0001_0000,
        S_CHK   = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_FETCH = 10'b00_1000_0000,
        S_DONE  = 10'b01_0000_0000,
        S_SPARE = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [COUNT_W-1:0] r_wp_count;
    logic [THR_W-1:0]   r_thr;
    logic [TIME_W-1:0]  r_dwell;

    // sequencer state
    logic [IDX_W-1:0]  r_ci;
    logic              r_flag;
    logic [TIME_W-1:0] r_atime;

    // sample operands and working registers
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [TIME_W-1:0]            r_now;
    logic [ACC_W-1:0]             r_prod;
    logic [ACC_W-1:0]             r_acc;

    // remainder unit
    logic [CNT_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;

    // table and output
    t_wp_entry r_mem [MAX_WAYPOINTS];
    t_wp_entry r_rd;
    t_rsp      r_out;
    logic      r_ovalid;

    logic in_acc;
    logic out_free;
    logic mem_we;

    logic signed [COORD_BITS-1:0] mul_a, mul_b;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [SQ_W-1:0]       sq;

    logic [CNT_W-1:0]  eff_cnt;
    logic              chk_near;
    logic              chk_adv;
    logic [TIME_W-1:0] elapsed;

    logic [CNT_W:0]   div_trial;
    logic             div_fits;
    logic [CNT_W-1:0] div_rem;
    logic             div_last;

    // handshake
    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_ovalid || o_rsp.ready;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;

    assign mem_we = in_acc && (i_req.payload.req_type == REQ_LOAD)
                    && (32'(i_req.payload.entry_index) < MAX_WAYPOINTS);

    // effective count: zero acts as one, large values clamp to the depth
    always_comb begin
        if (r_wp_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (32'(r_wp_count) > MAX_WAYPOINTS) begin
            eff_cnt = CNT_W'(MAX_WAYPOINTS);
        end else begin
            eff_cnt = CNT_W'(r_wp_count);
        end
    end

    // shared difference and square unit, one axis per cycle
    always_comb begin
        priority if (r_state == S_MX) begin
            mul_a = r_rd.x;
            mul_b = r_px;
        end else if (r_state == S_MY) begin
            mul_a = r_rd.y;
            mul_b = r_py;
        end else begin
            mul_a = r_rd.z;
            mul_b = r_pz;
        end
    end

    assign diff = DIFF_W'(mul_a) - DIFF_W'(mul_b);
    assign sq   = diff * diff;

    // arrival and dwell decision
    assign elapsed  = r_now - r_atime;
    assign chk_near = CMP_W'(r_acc) < CMP_W'(r_thr);
    assign chk_adv  = r_flag && (elapsed > r_dwell);

    // restoring remainder step
    assign div_trial = {r_rem, r_dvd[CNT_W-1]};
    assign div_fits  = div_trial >= {1'b0, r_dvs};
    assign div_rem   = div_fits ? CNT_W'(div_trial - {1'b0, r_dvs}) : CNT_W'(div_trial);
    assign div_last  = (r_step == STEP_W'(CNT_W - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_req.payload.req_type == REQ_LOAD) ? S_FETCH : S_MX;
                end
            end
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_MZ;
            S_MZ:    n_state = S_ACC;
            S_ACC:   n_state = S_CHK;
            S_CHK:   n_state = chk_adv ? S_DIV : S_DONE;
            S_DIV:   n_state = div_last ? S_FETCH : S_DIV;
            S_FETCH: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp_count <= WP_COUNT_RST;
            r_thr      <= THR_RST;
            r_dwell    <= DWELL_RST;
            r_ci       <= '0;
            r_flag     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WP_COUNT:   r_wp_count <= COUNT_W'(i_cfg_data);
                    CFG_ARRIVE_THR: r_thr      <= THR_W'(i_cfg_data);
                    CFG_DWELL:      r_dwell    <= TIME_W'(i_cfg_data);
                    default: ;
                endcase
            end

            if (r_state == S_CHK) begin
                if (chk_adv) begin
                    r_flag <= 1'b0;
                end else if (chk_near && !r_flag) begin
                    r_flag <= 1'b1;
                end
            end

            if (r_state == S_DIV && div_last) begin
                r_ci <= IDX_W'(div_rem);
            end

            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px  <= i_req.payload.coord_x;
            r_py  <= i_req.payload.coord_y;
            r_pz  <= i_req.payload.coord_z;
            r_now <= i_req.payload.now_ms;
        end

        if (r_state == S_MX || r_state == S_MY || r_state == S_MZ) begin
            r_prod <= ACC_W'($unsigned(sq));
        end

        priority if (r_state == S_MY) begin
            r_acc <= r_prod;
        end else if (r_state == S_MZ || r_state == S_ACC) begin
            r_acc <= r_acc + r_prod;
        end

        if (r_state == S_CHK && !chk_adv && chk_near && !r_flag) begin
            r_atime <= r_now;
        end

        if (r_state == S_CHK) begin
            r_dvd  <= CNT_W'(r_ci) + CNT_W'(1);
            r_dvs  <= eff_cnt;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == S_DIV) begin
            r_dvd  <= {r_dvd[CNT_W-2:0], 1'b0};
            r_rem  <= div_rem;
            r_step <= r_step + STEP_W'(1);
        end

        if (r_state == S_DONE && out_free) begin
            r_out.target_x       <= r_rd.x;
            r_out.target_y       <= r_rd.y;
            r_out.target_z       <= r_rd.z;
            r_out.target_heading <= r_rd.heading;
            r_out.target_index   <= TIDX_W'(r_ci);
            r_out.arrived        <= r_flag;
        end
    end

    // waypoint table, read continuously at the current index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[IDX_W'(i_req.payload.entry_index)] <= '{
                x:       i_req.payload.coord_x,
                y:       i_req.payload.coord_y,
                z:       i_req.payload.coord_z,
                heading: i_req.payload.heading
            };
        end
        r_rd <= r_mem[r_ci];
    end

    // checks
    `WPS_ASSERT_NXT(a_adv_clears_flag, (r_state == S_CHK) && chk_adv, !r_flag && (r_state == S_DIV))
    `WPS_ASSERT_NXT(a_wrap_in_range, (r_state == S_DIV) && div_last, CNT_W'(r_ci) < r_dvs)
    `WPS_ASSERT_NXT(a_load_keeps_seq, in_acc && (i_req.payload.req_type == REQ_LOAD), $stable(r_ci) && $stable(r_flag))
    `WPS_ASSERT_NXT(a_done_posts_beat, (r_state == S_DONE) && out_free, r_ovalid && (r_state == S_IDLE))

endmodule

`default_nettype wire
